// ----- hdl/hoc_pkg.sv -----
// Shared types and constants for the horizon occlusion culler.
// Used by hoc_div, hoc_mem and horizon_occlusion_culler_core.
package hoc_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 32;  // Q16.16 coordinates
    localparam int DIR_W     = 16;  // Q1.14 direction
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int VEC_W     = 33;  // coordinate minus camera
    localparam int PROD_W    = 49;  // direction times vector
    localparam int PROJ_W    = 50;  // projected lateral value or depth
    localparam int SLOPE_W   = 32;  // Q16.16 slope
    localparam int QUO_W     = 31;  // unsaturated slope magnitude
    localparam int LANES     = 3;   // lateral, low height, high height
    localparam int SCL_W     = 48;  // slope times scale
    localparam int COLT_W    = 49;  // scaled slope plus half
    localparam int COLP_W    = 63;  // times entry count
    localparam int COL_W     = 31;  // column index before clamping

    localparam int HOC_ENTRIES_DEF = 256;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAM_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd5;

    localparam logic signed [DIR_W-1:0]   DIR_Y_RST  = 16'sd16384;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN  = 32'sh8000_0000;
    localparam logic signed [SLOPE_W-1:0] SLOPE_SAT  = 32'sh7fff_ffff;
    // 0.33 in Q0.16
    localparam logic signed [15:0]        SCALE_033  = 16'sd21627;
    localparam logic signed [COLT_W-1:0]  HALF_Q32   = 49'sd2147483648;
    localparam logic signed [COLP_W-1:0]  CEIL_ADD   = 63'sd4294967295;

    // Divider request and response
    typedef struct packed {
        logic                          start;
        logic [PROJ_W-1:0]             den;
        logic [LANES-1:0][PROJ_W-1:0]  num;
    } div_req_t;

    typedef struct packed {
        logic                          done;
        logic [LANES-1:0][SLOPE_W-1:0] quo;
    } div_rsp_t;

endpackage

// ----- hdl/hoc_div.sv -----
// Three-lane radix-2 slope divider: num * 2^16 / den, truncated and saturated.
// Depends on hoc_pkg; one quotient bit per lane per cycle, lanes share den.
module hoc_div import hoc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [PROJ_W-1:0] den_reg;

    // Step counter shared by all lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QUO_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic                neg_reg;
        logic                sat_reg;
        logic [PROJ_W:0]     rem_reg;
        logic [QUO_W-1:0]    low_reg;
        logic [QUO_W-1:0]    quo_reg;
        logic [PROJ_W-1:0]   mag;
        logic [PROJ_W:0]     shifted;
        logic [PROJ_W:0]     diff;
        logic                take;
        logic [SLOPE_W-1:0]  q_ext;

        // Magnitude of the signed numerator
        assign mag = req.num[g][PROJ_W-1] ? (~req.num[g] + PROJ_W'(1)) : req.num[g];

        // One restoring step
        always_comb begin
            shifted = {rem_reg[PROJ_W-1:0], low_reg[QUO_W-1]};
            diff    = shifted - {1'b0, den_reg};
            take    = (shifted >= {1'b0, den_reg});
        end

        always_ff @(posedge aclk) begin
            if (req.start) begin
                neg_reg <= req.num[g][PROJ_W-1];
                sat_reg <= ((mag >> 15) >= req.den);
                rem_reg <= {1'b0, (mag >> 15)};
                low_reg <= {mag[14:0], 16'b0};
                quo_reg <= '0;
            end else if (busy_reg) begin
                rem_reg <= take ? diff : shifted;
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], take};
            end
        end

        // Apply sign and saturation
        assign q_ext = {1'b0, quo_reg};
        assign rsp.quo[g] = sat_reg ? (neg_reg ? -SLOPE_SAT : SLOPE_SAT)
                                    : (neg_reg ? (~q_ext + SLOPE_W'(1)) : q_ext);
    end

endmodule

// ----- hdl/hoc_mem.sv -----
// Horizon line storage: one write port, one read port, registered read data.
// Depends on hoc_pkg for the slope width.
module hoc_mem import hoc_pkg::*; #(
    parameter int DEPTH  = HOC_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [SLOPE_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [SLOPE_W-1:0] rdata
);

    logic [SLOPE_W-1:0] line_ram [DEPTH];
    logic [SLOPE_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            line_ram[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= line_ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/horizon_occlusion_culler_core.sv -----
// Horizon occlusion culler top level: sequencer, corner projection, column mapping.
// Depends on hoc_pkg, hoc_div and hoc_mem.
//
//  channel  | ports                         | role
//  ---------+-------------------------------+-------------------------------
//  cfg      | cfg_we, cfg_index, cfg_data   | camera, direction, enable
//  s_       | s_valid/s_ready, s_cmd, box_* | clear, add occluder, query box
//  m_       | m_valid/m_ready, m_occluded   | one result beat per input beat
//
// A box passes through projection of its four corners (31-step serial divider per
// corner), column mapping (scale, clamp, decide) and a walk of the horizon entries
// at one entry per cycle, each read through the registered line memory. A clear
// writes all HORIZON_ENTRIES entries. After reset a clearing pass of all entries
// runs with s_ready low; configuration writes are taken.
// A result beat waiting on m_ready does not block the next input beat.
module horizon_occlusion_culler_core import hoc_pkg::*; #(
    parameter int HORIZON_ENTRIES = HOC_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COORD_W-1:0]          cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_cmd,
    input  logic signed [COORD_W-1:0]   s_box_xmin,
    input  logic signed [COORD_W-1:0]   s_box_xmax,
    input  logic signed [COORD_W-1:0]   s_box_ymin,
    input  logic signed [COORD_W-1:0]   s_box_ymax,
    input  logic signed [COORD_W-1:0]   s_box_zmin,
    input  logic signed [COORD_W-1:0]   s_box_zmax,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_occluded
);

    localparam int IDX_W = $clog2(HORIZON_ENTRIES);
    localparam int PTR_W = IDX_W + 1;
    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(HORIZON_ENTRIES - 1);
    localparam logic signed [COL_W-1:0] LAST_COL = COL_W'(HORIZON_ENTRIES - 1);
    localparam logic signed [14:0]      ENT_S    = 15'(HORIZON_ENTRIES);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CORNER_MUL, ST_CORNER_SUM, ST_DIV,
        ST_COL_MUL, ST_COL_CLAMP, ST_DECIDE, ST_QUERY, ST_UPDATE, ST_DONE
    } state_t;

    // Configuration registers
    logic signed [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg;
    logic                      active_reg;

    // Sequencer and item registers
    state_t                    state_reg;
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [COORD_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [PROJ_W-1:0]  dzlo_reg, dzhi_reg;
    logic [1:0]                k_reg;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [SLOPE_W-1:0] xlo_reg, xhi_reg, zlo_reg, zhi_reg;
    logic signed [COLT_W-1:0]  tlo_reg, thi_reg;
    logic signed [COL_W-1:0]   aq_reg, bq_reg, au_reg, bu_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic [IDX_W-1:0]          end_reg;
    logic [IDX_W-1:0]          clr_idx_reg;
    logic                      clr_reply_reg;
    logic                      rd_vld_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      walk_upd_reg;
    logic                      occ_reg;
    logic                      m_valid_reg;
    logic                      m_occ_reg;

    // Combinational datapath
    logic signed [VEC_W-1:0]   vx, vy, dzl, dzh;
    logic signed [PROD_W-1:0]  pa, pb, pc, pd;
    logic signed [PROJ_W-1:0]  cx, cy;
    logic signed [SCL_W-1:0]   sc_lo, sc_hi;
    logic signed [COLP_W-1:0]  p_lo, p_hi;
    logic signed [COL_W-1:0]   fl_lo, ce_lo, fl_hi, ce_hi;
    logic signed [COL_W-1:0]   aq_c, bq_c, au_c, bu_c;
    logic signed [SLOPE_W-1:0] sx, s0, s1;
    logic signed [SLOPE_W-1:0] rdata_s;
    logic [SLOPE_W-1:0]        rdata;
    logic                      issue_en, q_fail, upd_we, mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [SLOPE_W-1:0]        mem_wdata;
    div_req_t                  dreq;
    div_rsp_t                  drsp;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            dir_x_reg  <= '0;
            dir_y_reg  <= DIR_Y_RST;
            active_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CAM_X:  cam_x_reg  <= cfg_data;
                REG_CAM_Y:  cam_y_reg  <= cfg_data;
                REG_CAM_Z:  cam_z_reg  <= cfg_data;
                REG_DIR_X:  dir_x_reg  <= cfg_data[DIR_W-1:0];
                REG_DIR_Y:  dir_y_reg  <= cfg_data[DIR_W-1:0];
                REG_ACTIVE: active_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Height offsets, scaled to Q.30 by 2^14
    assign dzl = VEC_W'(s_box_zmin) - VEC_W'(cam_z_reg);
    assign dzh = VEC_W'(s_box_zmax) - VEC_W'(cam_z_reg);

    // Corner relative to camera and its four products
    assign vx = (k_reg[1] ? VEC_W'(xmax_reg) : VEC_W'(xmin_reg)) - VEC_W'(cam_x_reg);
    assign vy = (k_reg[0] ? VEC_W'(ymax_reg) : VEC_W'(ymin_reg)) - VEC_W'(cam_y_reg);
    assign pa = dir_y_reg * vx;
    assign pb = dir_x_reg * vy;
    assign pc = dir_x_reg * vx;
    assign pd = dir_y_reg * vy;
    assign cx = PROJ_W'(pa_reg) - PROJ_W'(pb_reg);
    assign cy = -PROJ_W'(pc_reg) - PROJ_W'(pd_reg);

    // Divider launch for the three slopes of one corner
    assign dreq.start  = (state_reg == ST_CORNER_SUM) && (cy > 0);
    assign dreq.den    = cy;
    assign dreq.num[0] = cx;
    assign dreq.num[1] = dzlo_reg;
    assign dreq.num[2] = dzhi_reg;
    assign sx = drsp.quo[0];
    assign s0 = drsp.quo[1];
    assign s1 = drsp.quo[2];

    hoc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // Column mapping: floor and ceil of (slope*0.33 + 1/2) * entries
    assign sc_lo = xlo_reg * SCALE_033;
    assign sc_hi = xhi_reg * SCALE_033;
    assign p_lo  = tlo_reg * ENT_S;
    assign p_hi  = thi_reg * ENT_S;
    assign fl_lo = COL_W'(p_lo >>> 32);
    assign ce_lo = COL_W'((p_lo + CEIL_ADD) >>> 32);
    assign fl_hi = COL_W'(p_hi >>> 32);
    assign ce_hi = COL_W'((p_hi + CEIL_ADD) >>> 32);
    assign aq_c  = (fl_lo < 0) ? '0 : fl_lo;
    assign au_c  = (ce_lo < 0) ? '0 : ce_lo;
    assign bq_c  = (ce_hi > LAST_COL) ? LAST_COL : ce_hi;
    assign bu_c  = (fl_hi > LAST_COL) ? LAST_COL : fl_hi;

    // Horizon walk: one read issued per cycle, data checked in the next cycle
    assign rdata_s  = rdata;
    assign q_fail   = (state_reg == ST_QUERY) && rd_vld_reg && (zhi_reg > rdata_s);
    assign issue_en = ((state_reg == ST_QUERY) || (state_reg == ST_UPDATE))
                      && (ptr_reg <= {1'b0, end_reg}) && !q_fail;
    assign upd_we   = walk_upd_reg && rd_vld_reg && (zlo_reg > rdata_s);
    assign mem_we    = (state_reg == ST_CLEAR) || upd_we;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : rd_idx_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? SLOPE_MIN : zlo_reg;

    hoc_mem #(
        .DEPTH  (HORIZON_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue_en),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    // Sequencer, item registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clr_reply_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            walk_upd_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= issue_en;
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
            if (issue_en) begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
            // drop the result beat once taken, unless a new one is loaded
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == LAST_IDX) begin
                        clr_idx_reg <= '0;
                        occ_reg     <= 1'b0;
                        state_reg   <= clr_reply_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg  <= s_cmd;
                        xmin_reg <= s_box_xmin;
                        xmax_reg <= s_box_xmax;
                        ymin_reg <= s_box_ymin;
                        ymax_reg <= s_box_ymax;
                        dzlo_reg <= {{(PROJ_W - VEC_W - 14){dzl[VEC_W-1]}}, dzl, 14'b0};
                        dzhi_reg <= {{(PROJ_W - VEC_W - 14){dzh[VEC_W-1]}}, dzh, 14'b0};
                        k_reg    <= '0;
                        occ_reg  <= 1'b0;
                        if (s_cmd == CMD_CLEAR) begin
                            clr_reply_reg <= 1'b1;
                            state_reg     <= ST_CLEAR;
                        end else if (((s_cmd != CMD_ADD) && (s_cmd != CMD_QUERY))
                                     || !active_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_CORNER_MUL;
                        end
                    end
                end
                ST_CORNER_MUL: begin
                    pa_reg    <= pa;
                    pb_reg    <= pb;
                    pc_reg    <= pc;
                    pd_reg    <= pd;
                    state_reg <= ST_CORNER_SUM;
                end
                ST_CORNER_SUM: begin
                    // drop the box when a corner is not in front
                    state_reg <= (cy > 0) ? ST_DIV : ST_DONE;
                end
                ST_DIV: begin
                    if (drsp.done) begin
                        if ((k_reg == 2'd0) || (sx < xlo_reg)) xlo_reg <= sx;
                        if ((k_reg == 2'd0) || (sx > xhi_reg)) xhi_reg <= sx;
                        if ((k_reg == 2'd0) || (s0 < zlo_reg)) zlo_reg <= s0;
                        if ((k_reg == 2'd0) || (s1 > zhi_reg)) zhi_reg <= s1;
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? ST_COL_MUL : ST_CORNER_MUL;
                    end
                end
                ST_COL_MUL: begin
                    tlo_reg   <= COLT_W'(sc_lo) + HALF_Q32;
                    thi_reg   <= COLT_W'(sc_hi) + HALF_Q32;
                    state_reg <= ST_COL_CLAMP;
                end
                ST_COL_CLAMP: begin
                    aq_reg    <= aq_c;
                    bq_reg    <= bq_c;
                    au_reg    <= au_c;
                    bu_reg    <= bu_c;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (bq_reg >= aq_reg) begin
                        ptr_reg   <= aq_reg[PTR_W-1:0];
                        end_reg   <= bq_reg[IDX_W-1:0];
                        state_reg <= ST_QUERY;
                    end else if ((cmd_reg == CMD_ADD) && (bu_reg >= au_reg)) begin
                        ptr_reg      <= au_reg[PTR_W-1:0];
                        end_reg      <= bu_reg[IDX_W-1:0];
                        walk_upd_reg <= 1'b1;
                        state_reg    <= ST_UPDATE;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_QUERY: begin
                    if (q_fail) begin
                        if ((cmd_reg == CMD_ADD) && (bu_reg >= au_reg)) begin
                            ptr_reg      <= au_reg[PTR_W-1:0];
                            end_reg      <= bu_reg[IDX_W-1:0];
                            walk_upd_reg <= 1'b1;
                            state_reg    <= ST_UPDATE;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else if (ptr_reg > {1'b0, end_reg}) begin
                        occ_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_UPDATE: begin
                    // last write lands on the same edge as the exit
                    if (ptr_reg > {1'b0, end_reg}) begin
                        walk_upd_reg <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_occ_reg     <= occ_reg;
                        clr_reply_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_occluded = m_occ_reg;

    // Line writes come only from the clearing sweep or the raise walk
    a_we_src: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_UPDATE)))
        else $error("line write outside clear or update");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // Reads in flight stay inside the walked span
    a_rd_span: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (rd_idx_reg <= end_reg))
        else $error("horizon read beyond span end");

    // No read is in flight when a new beat can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!rd_vld_reg && !walk_upd_reg))
        else $error("walk still active in idle");

endmodule

// ----- tb/hoc_checker.sv -----
// Horizon culler scoreboard: watches input and result beats, predicts the occluded flag.
// Depends on hoc_pkg; instantiated by tb beside the core.
`timescale 1ns / 100ps
module hoc_checker import hoc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [CMD_W-1:0]          s_cmd,
    input  logic signed [COORD_W-1:0] s_box_xmin,
    input  logic signed [COORD_W-1:0] s_box_xmax,
    input  logic signed [COORD_W-1:0] s_box_ymin,
    input  logic signed [COORD_W-1:0] s_box_ymax,
    input  logic signed [COORD_W-1:0] s_box_zmin,
    input  logic signed [COORD_W-1:0] s_box_zmax,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_occluded,
    output int                        fail_count,
    output int                        pending
);
    localparam int NCOL = HOC_ENTRIES_DEF;

    logic signed [31:0] line_slope [NCOL];
    longint cx_cam, cy_cam, cz_cam, dx_view, dy_view;
    bit     culling_on;
    bit     occ_flags [$];

    function automatic longint SLOPE_MAX_L();
        return 64'sd2147483647;
    endfunction

    // num * 2^16 / den, truncated toward zero, saturated
    function automatic longint slope_of(longint num, longint den);
        longint mag, q, r;
        bit     neg;
        neg = num < 0;
        mag = neg ? -num : num;
        if ((mag >>> 15) >= den) return neg ? -SLOPE_MAX_L() : SLOPE_MAX_L();
        q = mag / den;
        r = mag % den;
        // long division for the 16 fraction bits keeps every term in range
        for (int k = 0; k < 16; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return neg ? -q : q;
    endfunction

    function automatic longint floor32(longint v);
        return v >>> 32;
    endfunction

    function automatic longint col_of(longint slope, bit up);
        longint p;
        p = (slope * 21627 + 64'sd2147483648) * NCOL;
        return up ? floor32(p + 64'sd4294967295) : floor32(p);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Predict the flag for one accepted beat and update the line
    function automatic bit predict_occluded(logic [CMD_W-1:0] cmd, longint bx0, longint bx1,
                                            longint by0, longint by1, longint bz0,
                                            longint bz1);
        longint xlo, xhi, zlo, zhi, dzlo, dzhi, vx, vy, cx, cy, sx, s0, s1, a, b;
        bit     occ;
        if (cmd == CMD_CLEAR) begin
            foreach (line_slope[i]) line_slope[i] = SLOPE_MIN;
            return 1'b0;
        end
        if (cmd != CMD_ADD && cmd != CMD_QUERY) return 1'b0;
        if (!culling_on) return 1'b0;
        dzlo = (bz0 - cz_cam) * 16384;
        dzhi = (bz1 - cz_cam) * 16384;
        for (int k = 0; k < 4; k++) begin
            vx = (k[1] ? bx1 : bx0) - cx_cam;
            vy = (k[0] ? by1 : by0) - cy_cam;
            cx = dy_view * vx - dx_view * vy;
            cy = -(dx_view * vx) - dy_view * vy;
            if (cy <= 0) return 1'b0;
            sx = slope_of(cx, cy);
            s0 = slope_of(dzlo, cy);
            s1 = slope_of(dzhi, cy);
            if (k == 0 || sx < xlo) xlo = sx;
            if (k == 0 || sx > xhi) xhi = sx;
            if (k == 0 || s0 < zlo) zlo = s0;
            if (k == 0 || s1 > zhi) zhi = s1;
        end
        a = col_of(xlo, 0);
        b = col_of(xhi, 1);
        if (a < 0) a = 0;
        if (b > NCOL - 1) b = NCOL - 1;
        occ = b >= a;
        for (longint i = a; occ && i <= b; i++)
            if (zhi > longint'(line_slope[i])) occ = 0;
        if (cmd == CMD_ADD && !occ) begin
            a = col_of(xlo, 1);
            b = col_of(xhi, 0);
            if (a < 0) a = 0;
            if (b > NCOL - 1) b = NCOL - 1;
            for (longint i = a; i <= b; i++)
                if (zlo > longint'(line_slope[i])) line_slope[i] = zlo[31:0];
        end
        return occ;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (line_slope[i]) line_slope[i] = SLOPE_MIN;
            cx_cam = 0; cy_cam = 0; cz_cam = 0;
            dx_view = 0; dy_view = DIR_Y_RST;
            culling_on = 0;
            occ_flags.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_CAM_X:  cx_cam = longint'(signed'(cfg_data));
                    REG_CAM_Y:  cy_cam = longint'(signed'(cfg_data));
                    REG_CAM_Z:  cz_cam = longint'(signed'(cfg_data));
                    REG_DIR_X:  dx_view = longint'(signed'(cfg_data[15:0]));
                    REG_DIR_Y:  dy_view = longint'(signed'(cfg_data[15:0]));
                    REG_ACTIVE: culling_on = cfg_data[0];
                    default: ;
                endcase
            end
            // compare result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (occ_flags.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else if (occ_flags.pop_front() !== m_occluded)
                    report_mismatch($sformatf("occluded=%0b wrong", m_occluded));
            end
            // predict on accepted input beat
            if (s_valid && s_ready)
                occ_flags.push_back(predict_occluded(s_cmd, s_box_xmin, s_box_xmax,
                    s_box_ymin, s_box_ymax, s_box_zmin, s_box_zmax));
            pending = occ_flags.size();
        end
    end
endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for horizon_occlusion_culler_core.
// Depends on hoc_pkg, the core and hoc_checker.
`timescale 1ns / 100ps
module tb;
    import hoc_pkg::*;

    logic                      aclk = 0, aresetn = 0;
    logic                      cfg_we = 0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_CAM_X;
    logic [COORD_W-1:0]        cfg_data = 0;
    logic                      s_valid = 0, s_ready, m_valid, m_ready = 0, m_occluded;
    logic [CMD_W-1:0]          s_cmd = CMD_CLEAR;
    logic signed [COORD_W-1:0] s_box_xmin = 0, s_box_xmax = 0, s_box_ymin = 0;
    logic signed [COORD_W-1:0] s_box_ymax = 0, s_box_zmin = 0, s_box_zmax = 0;
    int   fail_count, pending;
    bit   quiet_tail = 0, hold_off = 0;
    int   cycle_count = 0;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    horizon_occlusion_culler_core uut (.*);
    hoc_checker chk (.*);

    // give up at a generous limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 6000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                for (n = 0; n < 3000; n++) @(posedge aclk);
                hold_off = 0;
                m_ready <= 1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                m_ready <= 0;
                repeat (n) @(posedge aclk);
                m_ready <= 1;
            end else m_ready <= 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_coord(int sel);
        case (sel)
            0: return $urandom;
            1: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
            default: return $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000;
        endcase
    endfunction

    // present one beat and wait for acceptance
    task automatic send_box(logic [CMD_W-1:0] cmd, logic [31:0] x0, logic [31:0] x1,
                            logic [31:0] y0, logic [31:0] y1, logic [31:0] z0,
                            logic [31:0] z1);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1; s_cmd <= cmd;
        s_box_xmin <= x0; s_box_xmax <= x1; s_box_ymin <= y0;
        s_box_ymax <= y1; s_box_zmin <= z0; s_box_zmax <= z1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // well-formed box in front of a camera at the origin looking along -y
    task automatic send_front_box(logic [CMD_W-1:0] cmd);
        int cx, w, d, h, zb;
        cx = $urandom_range(0, 40 << 16) - (20 << 16);
        w  = $urandom_range(1 << 12, 8 << 16);
        d  = $urandom_range(2 << 16, 60 << 16);
        h  = $urandom_range(1 << 12, 6 << 16);
        zb = $urandom_range(0, 12 << 16) - (8 << 16);
        send_box(cmd, cx, cx + w, -d - w, -d, zb, zb + h);
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: culling off, then the extremes
        send_box(CMD_QUERY, 0, 1 << 16, -(5 << 16), -(4 << 16), 0, 1 << 16);
        s_valid <= 0;
        drain();
        write_reg(REG_DIR_X, 0);
        write_reg(REG_DIR_Y, 16'h4000);
        write_reg(REG_CAM_X, 0);
        write_reg(REG_CAM_Y, 0);
        write_reg(REG_CAM_Z, 0);
        write_reg(REG_DIR_Y, 16'hc000);
        write_reg(REG_ACTIVE, 1);
        send_box(CMD_ADD, -(4 << 16), 4 << 16, 4 << 16, 5 << 16, -(2 << 16), 1 << 16);
        send_box(CMD_QUERY, -(1 << 16), 1 << 16, 8 << 16, 9 << 16, -(1 << 16), 0);
        send_box(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
        send_box(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
        send_box(CMD_QUERY, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
        send_box(2'd3, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 0, 32'hffff_ffff);
        send_box(CMD_ADD, 1 << 16, 2 << 16, 1, 2, 32'h8000_0000, 32'h7fff_ffff);
        send_box(CMD_QUERY, 1 << 16, 2 << 16, 1 << 16, 2 << 16, 0, 1);
        send_box(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        send_box(CMD_QUERY, -(1 << 16), 1 << 16, 8 << 16, 9 << 16, -(1 << 16), 0);
        s_valid <= 0;
        drain();
        // random phases over several camera settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(REG_DIR_X, 0); write_reg(REG_DIR_Y, 16'h4000); end
                1: begin write_reg(REG_DIR_X, 16'hc000); write_reg(REG_DIR_Y, 0); end
                2: begin write_reg(REG_DIR_X, 16'h2d41); write_reg(REG_DIR_Y, 16'h2d41); end
                3: begin write_reg(REG_CAM_X, 32'h7fff_ffff); write_reg(REG_CAM_Z,
                         32'h8000_0000); write_reg(REG_ACTIVE, 0); end
                4: begin write_reg(REG_CAM_X, 0); write_reg(REG_CAM_Z, 0);
                         write_reg(REG_CAM_Y, $urandom_range(0, 1 << 18));
                         write_reg(REG_ACTIVE, 1); end
                5: write_reg(REG_CAM_Y, 32'h8000_0000);
                6: begin write_reg(REG_CAM_Y, 0); write_reg(REG_DIR_X, $urandom); end
                default: begin write_reg(REG_DIR_X, 0); write_reg(REG_DIR_Y, 16'h4000);
                         write_reg(REG_CAM_Z, $urandom_range(0, 1 << 17)); end
            endcase
            if (phase == 2) hold_off = 1;
            if (phase == 7) quiet_tail = 1;
            // mostly well-formed boxes at -y, or at +y in some phases; noise elsewhere
            repeat (225) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 3) send_box(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom);
                else if (r < 6) send_box(2'd3, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom);
                else if (r < 16) send_box($urandom_range(1, 2), rnd_coord(0),
                        rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
                        rnd_coord(0));
                else if (phase == 0 || phase >= 4) begin
                    // mirror the box to positive y
                    int cx, w, d, h, zb;
                    cx = $urandom_range(0, 40 << 16) - (20 << 16);
                    w  = $urandom_range(1 << 12, 8 << 16);
                    d  = $urandom_range(2 << 16, 60 << 16);
                    h  = $urandom_range(1 << 12, 6 << 16);
                    zb = $urandom_range(0, 12 << 16) - (8 << 16);
                    send_box($urandom_range(1, 2), cx, cx + w, d, d + w, zb, zb + h);
                end else send_front_box($urandom_range(1, 2));
            end
            s_valid <= 0;
            drain();
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- horizon_occlusion_culler_core.f -----
hdl/hoc_pkg.sv
hdl/hoc_div.sv
hdl/hoc_mem.sv
hdl/horizon_occlusion_culler_core.sv
tb/hoc_checker.sv
tb/tb.sv
